>>> rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/esg_pkg.sv
// Shared types and constants of the envelope shape generator.
`default_nettype none

package esg_pkg;

  // Output saturation
  localparam int LEVEL_BITS = 16;
  localparam logic [15:0] LEVEL_MAX = 16'((1 << LEVEL_BITS) - 1);

  // Shape codes
  localparam logic [1:0] MODE_SINE = 2'd0;
  localparam logic [1:0] MODE_FLAT = 2'd1;
  localparam logic [1:0] MODE_RAMP = 2'd2;
  localparam logic [1:0] MODE_TRI  = 2'd3;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_SHAPE  = 2'd0;
  localparam logic [1:0] REG_LENGTH = 2'd1;
  localparam logic [1:0] REG_PEAK   = 2'd2;

  // floor(x/3) = (x * RECIP_THREE) >> 17 for x < 2^17
  localparam logic [15:0] RECIP_THREE = 16'd43691;

  // Divider: 32-bit dividend, 16-bit divisor and quotient
  localparam int QUO_W              = 16;
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES         = QUO_W / DIV_BITS_PER_STAGE;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] length;
    logic [15:0] peak;
    logic [15:0] rise_len;
    logic [15:0] fall_len;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       oor;
    logic       rise;
  } side_t;

  typedef struct packed {
    logic [2*QUO_W-1:0] num;
    logic [QUO_W-1:0]   dvs;
    side_t              side;
  } div_req_t;

  typedef struct packed {
    logic [QUO_W-1:0] quo;
    side_t            side;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/esg_prep.sv
// Operand preparation: range checks, operand select, product and dividend.
`default_nettype none

module esg_prep #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  esg_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       in_index,
  output logic              out_valid,
  input  logic              out_ready,
  output esg_pkg::div_req_t out_req
);
  import esg_pkg::*;

  localparam logic [15:0] TWO_DEPTH = 16'(2 * SINE_TABLE_DEPTH);

  logic v0, v1, v2, v3;
  logic en0, en1, en2, en3;

  logic [15:0] idx0;
  logic [15:0] a1, b1, dvs1, off1;
  side_t       side1;
  logic [31:0] prod2;
  logic [15:0] dvs2, off2;
  side_t       side2;
  logic [31:0] num3;
  logic [15:0] dvs3;
  side_t       side3;

  logic        oor_c, rise_c;
  logic [15:0] fall_idx, a_c, b_c, dvs_c, off_c;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign en0      = !v0 || en1;
  assign in_ready = en0;

  // Stage 1 operand select
  always_comb begin
    oor_c    = idx0 >= cfg.length;
    rise_c   = idx0 < cfg.rise_len;
    fall_idx = idx0 - cfg.rise_len;
    a_c      = idx0;
    b_c      = cfg.peak;
    dvs_c    = cfg.length;
    off_c    = '0;
    case (cfg.mode)
      MODE_SINE: begin
        b_c = TWO_DEPTH;
      end
      MODE_FLAT: begin
        a_c   = '0;
        dvs_c = 16'd1;
      end
      MODE_TRI: begin
        if (rise_c) begin
          dvs_c = cfg.rise_len;
        end else begin
          // falling edge: ceiling division by the fall length
          a_c   = fall_idx;
          dvs_c = cfg.fall_len;
          off_c = cfg.fall_len - 16'd1;
        end
      end
      default: begin
        a_c = idx0;
      end
    endcase
    if (oor_c) begin
      a_c   = '0;
      dvs_c = 16'd1;
      off_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en0) v0 <= in_valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      idx0 <= in_index;
    end
    if (en1) begin
      a1    <= a_c;
      b1    <= b_c;
      dvs1  <= dvs_c;
      off1  <= off_c;
      side1 <= '{mode: cfg.mode, oor: oor_c, rise: rise_c};
    end
    if (en2) begin
      prod2 <= 32'(a1) * 32'(b1);
      dvs2  <= dvs1;
      off2  <= off1;
      side2 <= side1;
    end
    if (en3) begin
      num3  <= prod2 + 32'(off2);
      dvs3  <= dvs2;
      side3 <= side2;
    end
  end

  assign out_valid    = v3;
  assign out_req.num  = num3;
  assign out_req.dvs  = dvs3;
  assign out_req.side = side3;

endmodule

`default_nettype wire

>>> rtl/esg_div.sv
// Pipelined restoring divider, two quotient bits per stage.
`default_nettype none

module esg_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  esg_pkg::div_req_t in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output esg_pkg::div_rsp_t out_rsp
);
  import esg_pkg::*;

  logic [DIV_STAGES-1:0] stage_valid;
  logic [DIV_STAGES:0]   stage_en;
  logic [QUO_W-1:0]      rem  [DIV_STAGES];
  logic [QUO_W-1:0]      lo   [DIV_STAGES];
  logic [QUO_W-1:0]      quo  [DIV_STAGES];
  logic [QUO_W-1:0]      dvs  [DIV_STAGES];
  side_t                 side [DIV_STAGES];

  assign stage_en[DIV_STAGES] = out_ready;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [QUO_W-1:0] rem_in, lo_in, quo_in, dvs_in;
    logic [QUO_W-1:0] rem_out, lo_out, quo_out;
    side_t            side_in;
    logic             valid_in;
    logic             valid_q;
    logic [QUO_W-1:0] rem_q, lo_q, quo_q, dvs_q;
    side_t            side_q;

    if (s == 0) begin : g_first
      // upper half starts below the divisor, so the quotient fits QUO_W bits
      assign rem_in   = in_req.num[2*QUO_W-1:QUO_W];
      assign lo_in    = in_req.num[QUO_W-1:0];
      assign quo_in   = '0;
      assign dvs_in   = in_req.dvs;
      assign side_in  = in_req.side;
      assign valid_in = in_valid;
    end else begin : g_rest
      assign rem_in   = rem[s-1];
      assign lo_in    = lo[s-1];
      assign quo_in   = quo[s-1];
      assign dvs_in   = dvs[s-1];
      assign side_in  = side[s-1];
      assign valid_in = stage_valid[s-1];
    end

    always_comb begin
      logic [QUO_W:0] trial;
      rem_out = rem_in;
      lo_out  = lo_in;
      quo_out = quo_in;
      for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
        trial  = {rem_out, lo_out[QUO_W-1]};
        lo_out = {lo_out[QUO_W-2:0], 1'b0};
        if (trial >= {1'b0, dvs_in}) begin
          trial   = trial - {1'b0, dvs_in};
          quo_out = {quo_out[QUO_W-2:0], 1'b1};
        end else begin
          quo_out = {quo_out[QUO_W-2:0], 1'b0};
        end
        rem_out = trial[QUO_W-1:0];
      end
    end

    assign stage_en[s] = !valid_q || stage_en[s+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q <= 1'b0;
      end else if (stage_en[s]) begin
        valid_q <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (stage_en[s]) begin
        rem_q  <= rem_out;
        lo_q   <= lo_out;
        quo_q  <= quo_out;
        dvs_q  <= dvs_in;
        side_q <= side_in;
      end
    end

    assign stage_valid[s] = valid_q;
    assign rem[s]         = rem_q;
    assign lo[s]          = lo_q;
    assign quo[s]         = quo_q;
    assign dvs[s]         = dvs_q;
    assign side[s]        = side_q;
  end

  assign in_ready     = stage_en[0];
  assign out_valid    = stage_valid[DIV_STAGES-1];
  assign out_rsp.quo  = quo[DIV_STAGES-1];
  assign out_rsp.side = side[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> rtl/esg_post.sv
// Sine lookup, peak scaling, shape select and output register.
`default_nettype none

module esg_post #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  esg_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  esg_pkg::div_rsp_t in_rsp,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_level,
  output logic              out_oor
);
  import esg_pkg::*;

  localparam int ROM_AW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam logic [16:0] DEPTH17     = 17'(SINE_TABLE_DEPTH);
  localparam logic [16:0] TWO_DEPTH17 = 17'(2 * SINE_TABLE_DEPTH);
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint Q30_HALF    = 64'sd536870912;
  localparam longint TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

  // Quarter-wave sine entry in Q30, Taylor series to x^15, rounded to 16 bits
  function automatic logic [15:0] sine_entry(input longint k);
    longint a;
    longint term;
    longint total;
    longint e;
    a     = (k * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    term  = a;
    total = a;
    for (int n = 0; n < 7; n++) begin
      term  = (term * a) / Q30_ONE;
      term  = (term * a) / Q30_ONE;
      term  = term / TAYLOR_DIV[n];
      term  = -term;
      total = total + term;
    end
    if (total < 0) total = 0;
    e = (total * 65535 + Q30_HALF) / Q30_ONE;
    if (e > 65535) e = 65535;
    return e[15:0];
  endfunction

  logic [15:0] sine_rom [SINE_TABLE_DEPTH+1];

  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(longint'(g));
  end

  logic v0, v1, v2;
  logic en0, en1, en2;

  side_t       side0, side1;
  logic [15:0] quo0, quo1, rom_q;
  logic [31:0] prod1;
  logic [15:0] level2;
  logic        oor2;

  logic [16:0]       fold;
  logic [ROM_AW-1:0] rom_addr;
  logic [31:0]       scale_sum;
  logic [15:0]       level_c;

  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign en0      = !v0 || en1;
  assign in_ready = en0;

  // Mirror the half-period index onto the quarter wave
  always_comb begin
    if ({1'b0, in_rsp.quo} <= DEPTH17) begin
      fold = {1'b0, in_rsp.quo};
    end else begin
      fold = TWO_DEPTH17 - {1'b0, in_rsp.quo};
    end
    if (fold > DEPTH17) fold = DEPTH17;
    rom_addr = fold[ROM_AW-1:0];
  end

  // floor(v / 65535) as (v + (v >> 16) + 1) >> 16, exact for v <= 65535^2
  always_comb begin
    scale_sum = prod1 + {16'b0, prod1[31:16]} + 32'd1;
    case (side1.mode)
      MODE_SINE: level_c = scale_sum[31:16];
      MODE_FLAT: level_c = cfg.peak;
      MODE_RAMP: level_c = quo1;
      MODE_TRI: begin
        if (side1.rise) begin
          level_c = quo1;
        end else if (quo1 >= cfg.peak) begin
          level_c = '0;
        end else begin
          level_c = cfg.peak - quo1;
        end
      end
      default: level_c = quo1;
    endcase
    if (level_c > LEVEL_MAX) level_c = LEVEL_MAX;
    if (side1.oor) level_c = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en0) v0 <= in_valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      side0 <= in_rsp.side;
      quo0  <= in_rsp.quo;
      rom_q <= sine_rom[rom_addr];
    end
    if (en1) begin
      side1 <= side0;
      quo1  <= quo0;
      prod1 <= 32'(rom_q) * 32'(cfg.peak);
    end
    if (en2) begin
      level2 <= level_c;
      oor2   <= side1.oor;
    end
  end

  assign out_valid = v2;
  assign out_level = level2;
  assign out_oor   = oor2;

endmodule

`default_nettype wire

>>> rtl/envelope_shape_generator_core.sv
// Top level of the envelope shape generator: config registers and pipeline.
`default_nettype none
`include "assert_macros.svh"

// Channel  | Dir | Handshake          | Payload
// ---------+-----+--------------------+-------------------------------------
// s_*      | in  | s_tvalid/s_tready  | tdata[15:0] sample_index
// m_*      | out | m_tvalid/m_tready  | tdata[15:0] level, tuser[0] out_of_range
// apb      | in  | psel/penable/pready| 0x0 shape_mode, 0x4 pattern_length, 0x8 peak_level
//
// One index per cycle sustained while m_tready stays high; 4 operand stages, 8 divider
// stages (2 quotient bits each), 3 lookup/scale stages including the output register.
// The sine table ROM read is registered and takes one of the last three stages.
// Reset (rst, synchronous) clears valid bits and loads register defaults; no clear pass.
// Each stage holds when its successor is full and stalled, so bubbles close up and
// s_tready stays high while m_tvalid waits, until every stage holds an item.

module envelope_shape_generator_core #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // [15:0] sample_index
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // [15:0] level
  output logic        m_tuser,    // [0] out_of_range
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import esg_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0]  shape;
  logic [15:0] length;
  logic [15:0] peak;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape  <= MODE_SINE;
      length <= 16'd256;
      peak   <= 16'hFFFF;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_SHAPE:  shape  <= pwdata[1:0];
        REG_LENGTH: length <= pwdata[15:0];
        REG_PEAK:   peak   <= pwdata[15:0];
        default:    shape  <= shape;    // no register here, write dropped
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SHAPE:  prdata = {30'b0, shape};
      REG_LENGTH: prdata = {16'b0, length};
      REG_PEAK:   prdata = {16'b0, peak};
      default:    prdata = '0;
    endcase
  end

  // Triangle split, refreshed every cycle: rise = floor(2N/3), fall = N - rise.
  // Settles in the cycle after a write, before an index accepted after it reaches stage 1.
  logic [32:0] third_prod;
  logic [15:0] rise_len;
  logic [15:0] fall_len;

  assign third_prod = 33'({length, 1'b0}) * 33'(RECIP_THREE);

  always_ff @(posedge clk) begin
    rise_len <= third_prod[32:17];
    fall_len <= length - third_prod[32:17];
  end

  cfg_t cfg;
  assign cfg = '{mode: shape, length: length, peak: peak,
                 rise_len: rise_len, fall_len: fall_len};

  // ---------------------------------------------------------------------------
  // Pipeline: operand prep -> divider -> sine lookup / scale / select
  // ---------------------------------------------------------------------------
  logic     prep_ready;
  logic     req_valid, req_ready;
  div_req_t req;
  logic     rsp_valid, rsp_ready;
  div_rsp_t rsp;

  // hold off transfers while in reset
  assign s_tready = prep_ready && !rst;

  esg_prep #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid && s_tready),
    .in_ready (prep_ready),
    .in_index (s_tdata),
    .out_valid(req_valid),
    .out_ready(req_ready),
    .out_req  (req)
  );

  esg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req_valid),
    .in_ready (req_ready),
    .in_req   (req),
    .out_valid(rsp_valid),
    .out_ready(rsp_ready),
    .out_rsp  (rsp)
  );

  esg_post #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_post (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (rsp_valid),
    .in_ready (rsp_ready),
    .in_rsp   (rsp),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_level(m_tdata),
    .out_oor  (m_tuser)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // split registers follow the length register in the cycle after it changes
  logic split_ok;
  assign split_ok = (length == 16'd0) ||
                    (rise_len < length && 17'(rise_len) + 17'(fall_len) == 17'(length));

  `ASSERT_IMPLIES(a_oor_zero, clk, rst, m_tvalid && m_tuser, m_tdata == 16'd0, "out of range level not zero")
  `ASSERT_IMPLIES(a_level_le_peak, clk, rst, m_tvalid, m_tdata <= peak, "level above peak")
  `ASSERT_IMPLIES(a_div_nonzero, clk, rst, req_valid && !req.side.oor, req.dvs != 16'd0, "zero divisor on in-range index")
  `ASSERT_IMPLIES(a_tri_split, clk, rst, $stable(length), split_ok, "triangle split inconsistent")

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for envelope_shape_generator_core: APB setup, index stream, level check.

module tb_top;
  import esg_pkg::*;

  localparam int SINE_DEPTH     = 1024;
  localparam int PIPE_LATENCY   = 20;        // 15-stage pipe plus margin
  localparam int RX_HOLD_CYCLES = 60;        // long enough to fill every stage
  localparam int RANDOM_ITEMS   = 376;
  localparam int MAX_REPORTS    = 40;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int TIMEOUT_NS     = 1000000;   // far above the slowest run
  localparam int N_PROBES       = 24;

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint Q30_HALF_PI = 64'sd1686629713;   // pi/2 in Q30

  // Address 0xC decodes to no register; writes there must be dropped
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [15:0] index;
    logic [15:0] level;
    logic        oor;
  } level_exp_t;

  // One directed transfer with the register setting it needs.
  // typed_exp set: level/oor are the known answer, else the predictor decides.
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] length;
    logic [15:0] peak;
    logic [15:0] index;
    logic        typed_exp;
    logic [15:0] level;
    logic        oor;
  } probe_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;     // [15:0] sample_index
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;     // [15:0] level
  logic        m_tuser;     // [0] out_of_range
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the block's registers, updated when a write lands
  logic [1:0]  cfg_mode;
  logic [15:0] cfg_length;
  logic [15:0] cfg_peak;

  logic [15:0] sine_q16 [0:SINE_DEPTH];   // quarter-wave table, 65535 = 1.0
  level_exp_t  pending_levels [$];        // expected results, oldest first

  // Pacing knobs shared between the stimulus and receiver processes
  logic tx_calm;
  logic rx_calm;
  logic rx_hold_req;
  logic rx_holding;

  int err_count;
  int indexes_sent;
  int levels_checked;
  int oor_seen;
  int settings_used;
  int mode_hits [4];

  probe_t probes [N_PROBES] = '{
    // reset setting: half sine, 256 samples, full peak
    '{MODE_SINE, 16'd256,   16'hFFFF, 16'd0,     1'b1, 16'd0,     1'b0},
    '{MODE_SINE, 16'd256,   16'hFFFF, 16'd64,    1'b0, 16'd0,     1'b0},
    '{MODE_SINE, 16'd256,   16'hFFFF, 16'd128,   1'b0, 16'd0,     1'b0},
    '{MODE_SINE, 16'd256,   16'hFFFF, 16'd255,   1'b0, 16'd0,     1'b0},
    '{MODE_SINE, 16'd256,   16'hFFFF, 16'd256,   1'b1, 16'd0,     1'b1},
    '{MODE_SINE, 16'd256,   16'hFFFF, 16'hFFFF,  1'b1, 16'd0,     1'b1},
    // flat window, then a zero peak
    '{MODE_FLAT, 16'd100,   16'h1234, 16'd0,     1'b1, 16'h1234,  1'b0},
    '{MODE_FLAT, 16'd100,   16'h1234, 16'd99,    1'b1, 16'h1234,  1'b0},
    '{MODE_FLAT, 16'd100,   16'h0000, 16'd50,    1'b1, 16'd0,     1'b0},
    // ramp at full length and peak: level equals the index
    '{MODE_RAMP, 16'hFFFF,  16'hFFFF, 16'd0,     1'b1, 16'd0,     1'b0},
    '{MODE_RAMP, 16'hFFFF,  16'hFFFF, 16'h5555,  1'b1, 16'h5555,  1'b0},
    '{MODE_RAMP, 16'hFFFF,  16'hFFFF, 16'hFFFE,  1'b1, 16'hFFFE,  1'b0},
    '{MODE_RAMP, 16'hFFFF,  16'hFFFF, 16'hFFFF,  1'b1, 16'd0,     1'b1},
    // shortest triangle with both slopes: rise of 2, fall of 1
    '{MODE_TRI,  16'd3,     16'd100,  16'd0,     1'b1, 16'd0,     1'b0},
    '{MODE_TRI,  16'd3,     16'd100,  16'd1,     1'b1, 16'd50,    1'b0},
    '{MODE_TRI,  16'd3,     16'd100,  16'd2,     1'b1, 16'd100,   1'b0},
    '{MODE_TRI,  16'd3,     16'd100,  16'd3,     1'b1, 16'd0,     1'b1},
    // longest triangle around the apex at 43690
    '{MODE_TRI,  16'hFFFF,  16'hFFFF, 16'd43689, 1'b0, 16'd0,     1'b0},
    '{MODE_TRI,  16'hFFFF,  16'hFFFF, 16'd43690, 1'b1, 16'hFFFF,  1'b0},
    '{MODE_TRI,  16'hFFFF,  16'hFFFF, 16'hFFFE,  1'b0, 16'd0,     1'b0},
    // one-sample triangle: no rise at all, starts at the peak
    '{MODE_TRI,  16'd1,     16'hFFFF, 16'd0,     1'b1, 16'hFFFF,  1'b0},
    // zero length: every index is out of range; then lengths 1 and 65535
    '{MODE_SINE, 16'd0,     16'hFFFF, 16'd0,     1'b1, 16'd0,     1'b1},
    '{MODE_SINE, 16'd1,     16'hFFFF, 16'd0,     1'b1, 16'd0,     1'b0},
    '{MODE_SINE, 16'hFFFF,  16'hFFFF, 16'd32767, 1'b0, 16'd0,     1'b0}
  };

  envelope_shape_generator_core #(
    .SINE_TABLE_DEPTH(SINE_DEPTH)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #(TIMEOUT_NS);
    $display("timeout: stream stopped moving before the run completed");
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // sin(k*pi/(2D)) in Q30 by Taylor series to x^15, rounded to a 16-bit fraction.
  // Every product is truncated toward zero, term by term.
  function automatic logic [15:0] quarter_wave(int k);
    longint a;
    longint term;
    longint sum;
    longint e;
    int     n;
    a    = (longint'(k) * Q30_HALF_PI) / SINE_DEPTH;
    term = a;
    sum  = a;
    for (n = 1; n <= 7; n++) begin
      term = (term * a) / Q30_ONE;
      term = (term * a) / Q30_ONE;
      term = term / ((2 * n) * (2 * n + 1));
      term = -term;                  // sign alternates and carries to the next term
      sum += term;
    end
    if (sum < 0) sum = 0;
    e = (sum * 65535 + Q30_ONE / 2) / Q30_ONE;
    if (e > 65535) e = 65535;
    return e[15:0];
  endfunction

  function automatic level_exp_t envelope_at(logic [15:0] idx);
    longint unsigned i;
    longint unsigned n;
    longint unsigned p;
    longint unsigned d;
    longint unsigned x;
    longint unsigned q;
    longint unsigned r;
    longint unsigned fall;
    longint unsigned j;
    longint unsigned drop;
    longint unsigned lvl;
    level_exp_t      res;
    i   = idx;
    n   = cfg_length;
    p   = cfg_peak;
    d   = SINE_DEPTH;
    lvl = 0;
    res.index = idx;
    // also catches length 0
    if (i >= n) begin
      res.level = '0;
      res.oor   = 1'b1;
      return res;
    end
    case (cfg_mode)
      MODE_SINE: begin
        // map i onto 0..2D-1 and fold the second half back onto the quarter wave
        x = (i * 2 * d) / n;
        q = (x <= d) ? x : 2 * d - x;
        if (q > d) q = d;
        lvl = (sine_q16[q] * p) / 65535;
      end
      MODE_FLAT: lvl = p;
      MODE_RAMP: lvl = (i * p) / n;
      MODE_TRI: begin
        r    = (2 * n) / 3;
        fall = n - r;
        if (i < r) begin
          lvl = (i * p) / r;
        end else begin
          // falling edge uses a ceiling so the last sample approaches zero
          j    = i - r;
          drop = (j * p + fall - 1) / fall;
          lvl  = (drop >= p) ? 0 : p - drop;
        end
      end
      default: lvl = 0;
    endcase
    if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
    res.level = lvl[15:0];
    res.oor   = 1'b0;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [15:0] idx,
                                 input logic [15:0] got, input logic [15:0] want);
    if (err_count < MAX_REPORTS)
      $display("MISMATCH %s at index %0d: got %0h, expected %0h", what, idx, got, want);
    err_count++;
  endtask

  // Sampled in the active region of the edge, so DUT outputs still hold
  // their pre-edge values here.
  always @(posedge clk) begin : level_check
    level_exp_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_levels.size() == 0) begin
        report_mismatch("output transfer with nothing pending", 16'd0, m_tdata, 16'd0);
      end else begin
        want = pending_levels.pop_front();
        if (m_tdata !== want.level)
          report_mismatch("level", want.index, m_tdata, want.level);
        if (m_tuser !== want.oor)
          report_mismatch("out_of_range", want.index, 16'(m_tuser), 16'(want.oor));
        levels_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pacing
  // ---------------------------------------------------------------------------

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver: bursts of ready with random stalls, plus a long hold on request.
  // Each branch assigns m_tready at most once per edge.
  initial begin : rx_pacing
    int run;
    int gap;
    m_tready   <= 1'b0;
    rx_holding = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        m_tready   <= 1'b0;
        rx_holding = 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_holding  = 1'b0;
        rx_hold_req = 1'b0;
      end else begin
        run = $urandom_range(1, 8);
        m_tready <= 1'b1;
        repeat (run) @(posedge clk);
        gap = rx_calm ? 0 : pick_gap();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // APB write, setup then access phase; lands at the access edge with pready high.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SHAPE:  cfg_mode   = val[1:0];
      REG_LENGTH: cfg_length = val[15:0];
      REG_PEAK:   cfg_peak   = val[15:0];
      default: ;  // unmapped address, nothing changes
    endcase
    @(posedge clk);
  endtask

  // Offer one index and hold it until the transfer; tvalid stays up afterwards
  // so a following back-to-back index needs no second assignment in the step.
  task automatic push_index(input logic [15:0] idx, input logic typed_exp,
                            input logic [15:0] lvl, input logic oor);
    int         gap;
    level_exp_t want;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= idx;
    do @(posedge clk); while (!s_tready);
    if (typed_exp) begin
      want.index = idx;
      want.level = lvl;
      want.oor   = oor;
    end else begin
      want = envelope_at(idx);
    end
    pending_levels.push_back(want);
    indexes_sent++;
    mode_hits[cfg_mode]++;
    if (want.oor) oor_seen++;
  endtask

  // Stop offering and let the pipe empty before touching registers
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 3) == 0) ? 16'd0 : 16'hFFFF;
      1, 2, 3: return 16'($urandom_range(1, 16));
      4, 5, 6: return 16'($urandom_range(17, 2048));
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_peak();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Mostly inside the pattern; a fifth anywhere, which also toggles every bit
  function automatic logic [15:0] pick_index(logic [15:0] len);
    if (len == 0 || $urandom_range(0, 4) == 0) return 16'($urandom());
    return 16'($urandom_range(0, len - 1));
  endfunction

  initial begin : main_seq
    probe_t      p;
    logic [1:0]  new_mode;
    logic [15:0] new_len;
    logic [15:0] new_peak;
    int          k;
    int          phase;
    int          count;
    int          random_sent;
    int          wait_cycles;
    logic        hold;

    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    tx_calm     = 1'b0;
    rx_calm     = 1'b0;
    rx_hold_req = 1'b0;
    err_count      = 0;
    indexes_sent   = 0;
    levels_checked = 0;
    oor_seen       = 0;
    settings_used  = 1;
    for (k = 0; k < 4; k++) mode_hits[k] = 0;
    for (k = 0; k <= SINE_DEPTH; k++) sine_q16[k] = quarter_wave(k);

    // register defaults after reset
    cfg_mode   = MODE_SINE;
    cfg_length = 16'd256;
    cfg_peak   = 16'hFFFF;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: reprogram only when a row asks for another setting
    for (k = 0; k < N_PROBES; k++) begin
      p = probes[k];
      if (p.mode != cfg_mode || p.length != cfg_length || p.peak != cfg_peak) begin
        wait_idle();
        if (p.mode   != cfg_mode)   write_reg(REG_SHAPE,  {30'd0, p.mode});
        if (p.length != cfg_length) write_reg(REG_LENGTH, {16'd0, p.length});
        if (p.peak   != cfg_peak)   write_reg(REG_PEAK,   {16'd0, p.peak});
        settings_used++;
      end
      push_index(p.index, p.typed_exp, p.level, p.oor);
    end

    // Random phases: new setting each time, junk in the unused pwdata bits
    phase       = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      new_mode = 2'($urandom_range(0, 3));
      new_len  = pick_length();
      new_peak = pick_peak();
      write_reg(REG_SHAPE,  {30'($urandom()), new_mode});
      write_reg(REG_LENGTH, {16'($urandom()), new_len});
      write_reg(REG_PEAK,   {16'($urandom()), new_peak});
      // unmapped address must leave the setting alone
      if (phase == 0 || $urandom_range(0, 5) == 0) write_reg(REG_UNUSED, $urandom());
      settings_used++;

      // Back-pressure phase: receiver stalls long while indexes keep coming,
      // so every stage fills and s_tready has to drop.
      hold    = (phase == 1) || ($urandom_range(0, 9) == 0);
      tx_calm = hold || ($urandom_range(0, 3) == 0);
      rx_calm = !hold && ($urandom_range(0, 3) == 0);
      count   = hold ? 40 : $urandom_range(8, 40);
      if (hold) begin
        rx_hold_req = 1'b1;
        while (!rx_holding) @(posedge clk);
      end
      repeat (count) begin
        push_index(pick_index(new_len), 1'b0, 16'd0, 1'b0);
        random_sent++;
      end
      phase++;
    end

    // Drain, bounded so a lost result is reported rather than waited on forever
    tx_calm  = 1'b0;
    rx_calm  = 1'b0;
    s_tvalid <= 1'b0;
    wait_cycles = 0;
    while (pending_levels.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (PIPE_LATENCY) @(posedge clk);
    if (pending_levels.size() != 0)
      report_mismatch("results never delivered", pending_levels[0].index,
                      16'(pending_levels.size()), 16'd0);

    $display("Run: %0d index transfers, %0d levels checked, %0d register settings",
             indexes_sent, levels_checked, settings_used);
    $display("Shapes: sine %0d, flat %0d, ramp %0d, triangle %0d; out of range %0d",
             mode_hits[MODE_SINE], mode_hits[MODE_FLAT], mode_hits[MODE_RAMP],
             mode_hits[MODE_TRI], oor_seen);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", err_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
